@@ src/tks_pkg.sv @@
// Shared types, constants and codes for the tombstoned top-K selector.
package tks_pkg;

    parameter int SLOTS  = 4096;
    parameter int TOP_K  = 10;
    parameter int SLOT_W = $clog2(SLOTS);
    parameter int CNT_W  = $clog2(SLOTS + 1);
    parameter int FILL_W = $clog2(TOP_K + 1);
    parameter int DIST_W = 32;
    parameter int RANK_W = 4;

    parameter logic [DIST_W-1:0] DEAD_DISTANCE = 32'h7F7F_FFFD;

    localparam logic [2:0] ACT_PUSH   = 3'd0;
    localparam logic [2:0] ACT_BULK   = 3'd1;
    localparam logic [2:0] ACT_DELETE = 3'd2;
    localparam logic [2:0] ACT_UNDO   = 3'd3;
    localparam logic [2:0] ACT_SIZE   = 3'd4;
    localparam logic [2:0] ACT_DIST   = 3'd5;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_COUNT = 3'd1;
    localparam logic [2:0] STAT_RANGE     = 3'd2;
    localparam logic [2:0] STAT_DELETED   = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;
    localparam logic [2:0] STAT_NONE      = 3'd6;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FILL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  push_count;
        logic [DIST_W-1:0] distance;
        logic              final_item;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [CNT_W-1:0]  slot_number;
        logic [DIST_W-1:0] ranked_distance;
        logic [RANK_W-1:0] rank;
        logic              run_end;
    } out_item_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } chain_ctl_t;

endpackage

@@ src/tks_cell.sv @@
// One cell of the sorted candidate chain, holding a single (distance, slot) entry.
module tks_cell
    import tks_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_ctl_t        ctl,
    input  logic [DIST_W-1:0] new_dist,
    input  logic [SLOT_W-1:0] new_slot,
    input  logic              left_keep,
    input  entry_t            left_entry,
    input  entry_t            right_entry,
    output entry_t            entry,
    output logic              keep
);

    logic              valid_reg, valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    assign entry = '{valid: valid_reg, distance: dist_reg, slot: slot_reg};
    assign keep  = valid_reg &&
                   ((dist_reg < new_dist) || (dist_reg == new_dist && slot_reg <= new_slot));

    always_comb begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        slot_next  = slot_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            valid_next = right_entry.valid;
            dist_next  = right_entry.distance;
            slot_next  = right_entry.slot;
        end else if (ctl.insert && !keep) begin
            if (left_keep) begin
                valid_next = 1'b1;
                dist_next  = new_dist;
                slot_next  = new_slot;
            end else begin
                valid_next = left_entry.valid;
                dist_next  = left_entry.distance;
                slot_next  = left_entry.slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
        slot_reg <= slot_next;
    end

endmodule

@@ src/tks_chain.sv @@
// Row of candidate cells that keeps the smallest entries in ascending order.
module tks_chain
    import tks_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_ctl_t        ctl,
    input  logic [DIST_W-1:0] new_dist,
    input  logic [SLOT_W-1:0] new_slot,
    output entry_t            head,
    output logic [FILL_W-1:0] fill_after
);

    entry_t            cell_q [TOP_K];
    logic              keep   [TOP_K];
    logic [FILL_W-1:0] filled_reg, filled_next;
    logic              grows;

    for (genvar i = 0; i < TOP_K; i++) begin : g_cell
        logic   left_keep;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_entry = '0;
        end else begin : g_inner
            assign left_keep  = keep[i-1];
            assign left_entry = cell_q[i-1];
        end

        if (i == TOP_K - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_body
            assign right_entry = cell_q[i+1];
        end

        tks_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .new_dist    (new_dist),
            .new_slot    (new_slot),
            .left_keep   (left_keep),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_q[i]),
            .keep        (keep[i])
        );
    end

    assign head       = cell_q[0];
    assign grows      = ctl.insert && !keep[TOP_K-1] && (filled_reg < FILL_W'(TOP_K));
    assign fill_after = filled_reg + FILL_W'(grows);

    always_comb begin
        filled_next = filled_reg;
        if (ctl.clear) begin
            filled_next = '0;
        end else if (ctl.shift) begin
            if (filled_reg != '0) begin
                filled_next = filled_reg - FILL_W'(1);
            end
        end else if (ctl.insert) begin
            filled_next = fill_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= '0;
        end else begin
            filled_reg <= filled_next;
        end
    end

endmodule

@@ src/tombstoned_top_k_selector.sv @@
// Top level of the tombstoned top-K selector: slot table, command control and result port.
// Non-final distance transactions are taken one per cycle while the block runs with no other
// command held; each passes through a registered read of the alive-flag memory and is then
// inserted into a chain of TOP_K compare cells. Every other command, and the final distance
// transaction, must complete, with any wait for the result port, before the next is taken.
// A successful bulk push then writes one alive flag per cycle, push_count in all, through the
// single write port of the flag memory. A final distance transaction emits its ranked results
// one per cycle as they are taken, shifting the cell chain toward its head after each one.
module tombstoned_top_k_selector
    import tks_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_result
);

    logic flags_mem [SLOTS];

    state_t            state_reg, state_next;
    logic              p_valid_reg, p_valid_next;
    in_item_t          p_item_reg;
    logic              flag_rd_reg;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  dead_reg, dead_next;
    logic [SLOT_W-1:0] fill_addr_reg, fill_addr_next;
    logic [CNT_W-1:0]  fill_left_reg, fill_left_next;
    logic [FILL_W-1:0] emit_left_reg, emit_left_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    logic              m_valid_reg;
    out_item_t         m_result_reg;

    logic              accept;
    logic              out_free;
    logic              is_dist;
    logic              needs_out;
    logic              b_done;
    logic              in_range;
    logic [CNT_W-1:0]  alive;
    logic [FILL_W-1:0] emit_n;
    logic              load_out;
    out_item_t         res;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [SLOT_W-1:0] mem_raddr;
    chain_ctl_t        ctl;
    logic [DIST_W-1:0] ins_dist;
    entry_t            head;
    logic [FILL_W-1:0] fill_after;

    tks_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .new_dist   (ins_dist),
        .new_slot   (p_item_reg.slot_index),
        .head       (head),
        .fill_after (fill_after)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign is_dist  = (p_item_reg.action == ACT_DIST);
    assign needs_out = (p_item_reg.action == ACT_PUSH) || (p_item_reg.action == ACT_BULK) ||
                       (p_item_reg.action == ACT_DELETE) || (p_item_reg.action == ACT_UNDO) ||
                       (p_item_reg.action == ACT_SIZE) || (is_dist && p_item_reg.final_item);
    assign b_done   = p_valid_reg && (state_reg == ST_RUN) && (!needs_out || out_free);
    assign s_ready  = (state_reg == ST_RUN) &&
                      (!p_valid_reg || (is_dist && !p_item_reg.final_item));
    assign accept   = s_valid && s_ready;
    assign in_range = CNT_W'(p_item_reg.slot_index) < used_reg;
    assign ins_dist = flag_rd_reg ? p_item_reg.distance : DEAD_DISTANCE;
    assign alive    = (used_reg > dead_reg) ? used_reg - dead_reg : '0;
    assign emit_n   = (alive < CNT_W'(fill_after)) ? FILL_W'(alive) : fill_after;
    assign mem_raddr = (s_item.action == ACT_UNDO) ? SLOT_W'(used_reg - CNT_W'(1))
                                                   : s_item.slot_index;

    always_comb begin
        state_next     = state_reg;
        p_valid_next   = p_valid_reg;
        used_next      = used_reg;
        dead_next      = dead_reg;
        fill_addr_next = fill_addr_reg;
        fill_left_next = fill_left_reg;
        emit_left_next = emit_left_reg;
        rank_next      = rank_reg;
        load_out       = 1'b0;
        res            = '0;
        res.run_end    = 1'b1;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = 1'b1;
        ctl            = '0;

        if (b_done) begin
            p_valid_next = 1'b0;
            load_out     = needs_out;
            case (p_item_reg.action)
                ACT_PUSH: begin
                    if (used_reg >= CNT_W'(SLOTS)) begin
                        res.status = STAT_FULL;
                    end else begin
                        res.slot_number = used_reg;
                        mem_we          = 1'b1;
                        mem_waddr       = SLOT_W'(used_reg);
                        used_next       = used_reg + CNT_W'(1);
                    end
                end
                ACT_BULK: begin
                    if (p_item_reg.push_count == '0) begin
                        res.status = STAT_BAD_COUNT;
                    end else if (p_item_reg.push_count > CNT_W'(SLOTS) - used_reg) begin
                        res.status = STAT_FULL;
                    end else begin
                        res.slot_number = used_reg;
                        used_next       = used_reg + p_item_reg.push_count;
                        fill_addr_next  = SLOT_W'(used_reg);
                        fill_left_next  = p_item_reg.push_count;
                        state_next      = ST_FILL;
                    end
                end
                ACT_DELETE: begin
                    if (!in_range) begin
                        res.status = STAT_RANGE;
                    end else if (!flag_rd_reg) begin
                        res.status = STAT_DELETED;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = p_item_reg.slot_index;
                        mem_wdata = 1'b0;
                        dead_next = dead_reg + CNT_W'(1);
                    end
                end
                ACT_UNDO: begin
                    if (used_reg == '0) begin
                        res.status = STAT_EMPTY;
                    end else begin
                        used_next = used_reg - CNT_W'(1);
                        if (!flag_rd_reg && dead_reg != '0) begin
                            dead_next = dead_reg - CNT_W'(1);
                        end
                        mem_we    = 1'b1;
                        mem_waddr = SLOT_W'(used_reg - CNT_W'(1));
                    end
                end
                ACT_SIZE: begin
                    res.slot_number = used_reg;
                end
                ACT_DIST: begin
                    ctl.insert = in_range;
                    if (p_item_reg.final_item) begin
                        if (emit_n == '0) begin
                            res.status = STAT_NONE;
                            ctl.clear  = 1'b1;
                        end else begin
                            load_out       = 1'b0;
                            state_next     = ST_EMIT;
                            emit_left_next = emit_n;
                            rank_next      = '0;
                        end
                    end
                end
                default: begin
                    load_out = 1'b0;
                end
            endcase
        end

        case (state_reg)
            ST_FILL: begin
                mem_we         = 1'b1;
                mem_waddr      = fill_addr_reg;
                fill_addr_next = fill_addr_reg + SLOT_W'(1);
                fill_left_next = fill_left_reg - CNT_W'(1);
                if (fill_left_reg == CNT_W'(1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out            = 1'b1;
                    res.status          = STAT_OK;
                    res.slot_number     = CNT_W'(head.slot);
                    res.ranked_distance = head.distance;
                    res.rank            = rank_reg;
                    res.run_end         = (emit_left_reg == FILL_W'(1));
                    ctl.shift           = 1'b1;
                    rank_next           = rank_reg + RANK_W'(1);
                    emit_left_next      = emit_left_reg - FILL_W'(1);
                    if (emit_left_reg == FILL_W'(1)) begin
                        ctl.clear  = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
            end
        endcase

        if (accept) begin
            p_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            flags_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            flag_rd_reg <= flags_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            p_valid_reg <= 1'b0;
            used_reg    <= '0;
            dead_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= p_valid_next;
            used_reg    <= used_next;
            dead_reg    <= dead_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_item_reg <= s_item;
        end
        if (load_out) begin
            m_result_reg <= res;
        end
        fill_addr_reg <= fill_addr_next;
        fill_left_reg <= fill_left_next;
        emit_left_reg <= emit_left_next;
        rank_reg      <= rank_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    a_used_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(SLOTS))
        else $error("Used count exceeds the slot capacity.");

    a_dead_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        dead_reg <= used_reg)
        else $error("Dead count exceeds the used count.");

    a_emit_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> head.valid)
        else $error("Ranked result taken from an empty chain cell.");

endmodule

@@ tb/sv/tb_tombstoned_top_k_selector.sv @@
// Self-checking testbench for the tombstoned top-K selector with a slot-table scoreboard.
`timescale 1ns / 100ps

module tb_tombstoned_top_k_selector;
    import tks_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned ITEM_TARGET = 390;

    class slot_table_scoreboard;
        bit                alive[SLOTS];
        int unsigned       used_slots;
        int unsigned       dead_slots;
        logic [SLOT_W-1:0] best_slot[TOP_K];
        logic [DIST_W-1:0] best_dist[TOP_K];
        int unsigned       best_count;
        out_item_t         pending_replies[$];
        int unsigned       mismatches;

        function new();
            used_slots = 0;
            dead_slots = 0;
            mismatches = 0;
            clear_ranking();
        endfunction

        function void clear_ranking();
            best_count = 0;
            foreach (best_dist[i]) best_dist[i] = '1;
        endfunction

        function void push_reply(logic [2:0] st, int unsigned num, logic [DIST_W-1:0] d,
                                 int unsigned r, bit last);
            out_item_t rep;
            rep.status          = st;
            rep.slot_number     = CNT_W'(num);
            rep.ranked_distance = d;
            rep.rank            = RANK_W'(r);
            rep.run_end         = last;
            pending_replies.push_back(rep);
        endfunction

        function void rank_entry(logic [SLOT_W-1:0] s, logic [DIST_W-1:0] d);
            int unsigned pos;
            int unsigned i;
            pos = 0;
            while (pos < best_count && (best_dist[pos] < d ||
                   (best_dist[pos] == d && best_slot[pos] <= s)))
                pos++;
            if (pos >= TOP_K) return;
            i = (best_count < TOP_K) ? best_count : TOP_K - 1;
            while (i > pos) begin
                best_slot[i] = best_slot[i-1];
                best_dist[i] = best_dist[i-1];
                i--;
            end
            best_slot[pos] = s;
            best_dist[pos] = d;
            if (best_count < TOP_K) best_count++;
        endfunction

        function void note_command(in_item_t it);
            int unsigned count;
            int unsigned live;
            int unsigned n;
            int unsigned r;
            count = it.push_count;
            case (it.action)
                ACT_PUSH: begin
                    if (used_slots >= SLOTS) begin
                        push_reply(STAT_FULL, 0, 0, 0, 1);
                    end else begin
                        alive[used_slots] = 1'b1;
                        push_reply(STAT_OK, used_slots, 0, 0, 1);
                        used_slots++;
                    end
                end
                ACT_BULK: begin
                    if (count == 0) begin
                        push_reply(STAT_BAD_COUNT, 0, 0, 0, 1);
                    end else if (count > SLOTS - used_slots) begin
                        push_reply(STAT_FULL, 0, 0, 0, 1);
                    end else begin
                        for (r = 0; r < count; r++) alive[used_slots + r] = 1'b1;
                        push_reply(STAT_OK, used_slots, 0, 0, 1);
                        used_slots += count;
                    end
                end
                ACT_DELETE: begin
                    if (it.slot_index >= used_slots) begin
                        push_reply(STAT_RANGE, 0, 0, 0, 1);
                    end else if (!alive[it.slot_index]) begin
                        push_reply(STAT_DELETED, 0, 0, 0, 1);
                    end else begin
                        alive[it.slot_index] = 1'b0;
                        dead_slots++;
                        push_reply(STAT_OK, 0, 0, 0, 1);
                    end
                end
                ACT_UNDO: begin
                    if (used_slots == 0) begin
                        push_reply(STAT_EMPTY, 0, 0, 0, 1);
                    end else begin
                        used_slots--;
                        if (!alive[used_slots] && dead_slots > 0) dead_slots--;
                        alive[used_slots] = 1'b1;
                        push_reply(STAT_OK, 0, 0, 0, 1);
                    end
                end
                ACT_SIZE: begin
                    push_reply(STAT_OK, used_slots, 0, 0, 1);
                end
                ACT_DIST: begin
                    if (it.slot_index < used_slots)
                        rank_entry(it.slot_index,
                                   alive[it.slot_index] ? it.distance : DEAD_DISTANCE);
                    if (it.final_item) begin
                        live = (used_slots > dead_slots) ? used_slots - dead_slots : 0;
                        n = (live < best_count) ? live : best_count;
                        if (n == 0) begin
                            push_reply(STAT_NONE, 0, 0, 0, 1);
                        end else begin
                            for (r = 0; r < n; r++)
                                push_reply(STAT_OK, best_slot[r], best_dist[r], r, r + 1 == n);
                        end
                        clear_ranking();
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_reply(out_item_t got);
            out_item_t want;
            if (pending_replies.size() == 0) begin
                if (mismatches < 10)
                    $display("[%0t] unexpected result: status %0d slot %0d dist %h rank %0d",
                             $time, got.status, got.slot_number, got.ranked_distance,
                             got.rank);
                mismatches++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status || got.slot_number !== want.slot_number ||
                got.ranked_distance !== want.ranked_distance || got.rank !== want.rank ||
                got.run_end !== want.run_end) begin
                if (mismatches < 10) begin
                    $display("[%0t] expected status %0d slot %0d dist %h rank %0d end %0b",
                             $time, want.status, want.slot_number, want.ranked_distance,
                             want.rank, want.run_end);
                    $display("[%0t] actual   status %0d slot %0d dist %h rank %0d end %0b",
                             $time, got.status, got.slot_number, got.ranked_distance,
                             got.rank, got.run_end);
                end
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return pending_replies.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_result;

    slot_table_scoreboard sb = new();
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_stall    = 0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;

    tombstoned_top_k_selector dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always #2 aclk = ~aclk;

    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 75) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!rx_quiet && $urandom_range(0, 99) < 30) rx_stall <= idle_len();
        end
        if (cycle_count % 300 == 0) rx_quiet <= ($urandom_range(0, 9) < 3);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            sb.check_reply(m_result);
        end
    end

    function automatic in_item_t scrambled_item(logic [2:0] act);
        in_item_t it;
        it.action     = act;
        it.slot_index = SLOT_W'($urandom);
        it.push_count = CNT_W'($urandom);
        it.distance   = $urandom;
        it.final_item = 1'($urandom);
        return it;
    endfunction

    function automatic logic [DIST_W-1:0] pick_distance();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30) return DIST_W'($urandom_range(0, 3));
        if (r < 40) return DEAD_DISTANCE + DIST_W'($urandom_range(0, 2)) - 1;
        if (r < 45) return '1;
        return $urandom;
    endfunction

    task automatic send(in_item_t it);
        int unsigned gap;
        gap = (!tx_quiet && $urandom_range(0, 99) < 45) ? idle_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(it);
        if (it.action <= ACT_DIST) items_sent++;
    endtask

    task automatic wait_for_replies();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic send_cmd(logic [2:0] act);
        send(scrambled_item(act));
    endtask

    task automatic send_delete(int unsigned slot);
        in_item_t it;
        it = scrambled_item(ACT_DELETE);
        it.slot_index = SLOT_W'(slot);
        send(it);
    endtask

    task automatic send_bulk(int unsigned count);
        in_item_t it;
        it = scrambled_item(ACT_BULK);
        it.push_count = CNT_W'(count);
        send(it);
    endtask

    task automatic send_dist(int unsigned slot, logic [DIST_W-1:0] d, bit fin);
        in_item_t it;
        it = scrambled_item(ACT_DIST);
        it.slot_index = SLOT_W'(slot);
        it.distance   = d;
        it.final_item = fin;
        send(it);
    endtask

    task automatic run_query();
        int unsigned n;
        int unsigned s;
        int unsigned r;
        n = sb.used_slots;
        if (n == 0) begin
            send_dist($urandom_range(0, SLOTS - 1), pick_distance(), 1'b1);
            return;
        end
        for (s = 0; s < n; s++) begin
            r = $urandom_range(0, 99);
            if (r < 3 && n < SLOTS)
                send_dist($urandom_range(n, SLOTS - 1), pick_distance(), 1'b0);
            else if (r < 6) send_dist(s, pick_distance(), 1'b0);
            else if (r < 9) send_delete($urandom_range(0, n));
            else if (r < 11) send_cmd(ACT_SIZE);
            send_dist((r >= 11 && r < 15) ? $urandom_range(0, n - 1) : s, pick_distance(),
                      s == n - 1);
        end
    endtask

    task automatic edit_table();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sb.used_slots > 40) repeat ($urandom_range(2, 10)) send_cmd(ACT_UNDO);
        else if (r < 25) repeat ($urandom_range(1, 4)) send_cmd(ACT_PUSH);
        else if (r < 50) send_bulk($urandom_range(1, 12));
        else if (r < 75)
            repeat ($urandom_range(1, 3)) send_delete($urandom_range(0, sb.used_slots + 1));
        else if (r < 85) repeat ($urandom_range(1, 2)) send_cmd(ACT_UNDO);
        else if (r < 92) send_cmd(ACT_SIZE);
        else
            send_bulk($urandom_range(0, 1) ? 0
                                           : $urandom_range(SLOTS - sb.used_slots + 1, 8191));
    endtask

    task automatic wipe_table();
        int unsigned s;
        for (s = 0; s < sb.used_slots; s++)
            if (sb.alive[s]) send_delete(s);
    endtask

    task automatic send_noise();
        in_item_t it;
        it = scrambled_item(3'($urandom_range(0, 7)));
        if (it.action == ACT_BULK)
            it.push_count = CNT_W'($urandom_range(0, 1) ? $urandom_range(1, 6)
                                   : $urandom_range(SLOTS - sb.used_slots + 1, 8191));
        if (it.action == ACT_PUSH && sb.used_slots > 40) it.action = ACT_SIZE;
        send(it);
    endtask

    initial begin
        int unsigned r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_cmd(ACT_UNDO);
        send_cmd(ACT_SIZE);
        send_delete(0);
        send_delete(SLOTS - 1);
        send_bulk(0);
        send_bulk('1);
        send_bulk(SLOTS + 1);
        send_dist(0, 32'h3F80_0000, 1'b1);
        send_cmd(ACT_PUSH);
        send_bulk(5);
        send_delete(2);
        send_delete(2);
        send_dist(0, 5, 1'b0);
        send_dist(1, 5, 1'b0);
        send_dist(2, 0, 1'b0);
        send_dist(3, '1, 1'b0);
        send_dist(4, DEAD_DISTANCE, 1'b0);
        send_dist(5, 0, 1'b1);
        send_cmd(ACT_SPARE_LO);
        send_cmd(ACT_SPARE_HI);
        send_cmd(ACT_UNDO);
        send_delete(4);
        send_cmd(ACT_UNDO);
        send_dist(SLOTS - 1, $urandom, 1'b1);
        send_cmd(ACT_SIZE);
        wait_for_replies();

        while (items_sent < ITEM_TARGET) begin
            tx_quiet = ($urandom_range(0, 9) < 3);
            r = $urandom_range(0, 99);
            if (r < 45) run_query();
            else if (r < 80) edit_table();
            else if (r < 85) begin
                wipe_table();
                run_query();
            end else send_noise();
            if ($urandom_range(0, 99) < 5) wait_for_replies();
        end

        wait_for_replies();
        send_bulk(SLOTS - sb.used_slots);
        send_cmd(ACT_PUSH);
        send_bulk(1);
        send_cmd(ACT_SIZE);
        send_delete(SLOTS - 1);
        send_delete(SLOTS - 1);
        send_dist(SLOTS - 2, pick_distance(), 1'b0);
        send_dist(SLOTS - 1, pick_distance(), 1'b0);
        send_dist(0, pick_distance(), 1'b1);
        send_cmd(ACT_UNDO);
        send_cmd(ACT_SIZE);
        send_cmd(ACT_PUSH);

        wait_for_replies();
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
